### src/urpa_pkg.sv
// ----------------------------------------------------------------------------
// urpa_pkg
// Types, codes and helpers shared by the root port attach sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package urpa_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned LINE_W  = 3;
	localparam int unsigned CODE_W  = 4;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned IDATA_W = 8;
	localparam int unsigned ODATA_W = 16;

	localparam logic [LINE_W-1:0] LINE_SE0  = 3'd0;
	localparam logic [LINE_W-1:0] LINE_SE1  = 3'd1;
	localparam logic [LINE_W-1:0] LINE_LOW  = 3'd2;
	localparam logic [LINE_W-1:0] LINE_FULL = 3'd3;

	localparam logic OP_POLL = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CIDX_W-1:0] REG_SETTLE     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SOF_SETTLE = 2'd1;
	localparam logic [CIDX_W-1:0] REG_RECOVER    = 2'd2;

	localparam logic [TICK_W-1:0] SETTLE_RESET     = 16'd200;
	localparam logic [TICK_W-1:0] SOF_SETTLE_RESET = 16'd200;
	localparam logic [TICK_W-1:0] RECOVER_RESET    = 16'd20;

	localparam logic [CODE_W-1:0] CODE_WAITDEV = 4'd0;
	localparam logic [CODE_W-1:0] CODE_INIT    = 4'd1;
	localparam logic [CODE_W-1:0] CODE_ILLEGAL = 4'd2;
	localparam logic [CODE_W-1:0] CODE_SETTLE  = 4'd3;
	localparam logic [CODE_W-1:0] CODE_RESET   = 4'd4;
	localparam logic [CODE_W-1:0] CODE_WAITRST = 4'd5;
	localparam logic [CODE_W-1:0] CODE_WAITSOF = 4'd6;
	localparam logic [CODE_W-1:0] CODE_RECOVER = 4'd7;
	localparam logic [CODE_W-1:0] CODE_CONFIG  = 4'd8;
	localparam logic [CODE_W-1:0] CODE_RUNNING = 4'd9;

	typedef enum logic [9:0] {
		ST_WAITDEV = 10'b00_0000_0001,
		ST_INIT    = 10'b00_0000_0010,
		ST_ILLEGAL = 10'b00_0000_0100,
		ST_SETTLE  = 10'b00_0000_1000,
		ST_RESET   = 10'b00_0001_0000,
		ST_WAITRST = 10'b00_0010_0000,
		ST_WAITSOF = 10'b00_0100_0000,
		ST_RECOVER = 10'b00_1000_0000,
		ST_CONFIG  = 10'b01_0000_0000,
		ST_RUNNING = 10'b10_0000_0000
	} seq_state_t;

	typedef struct packed {
		logic              opcode;
		logic [LINE_W-1:0] line_state;
		logic              reset_busy;
		logic              frame_seen;
	} item_t;

	typedef struct packed {
		logic [TICK_W-1:0] settle_ticks;
		logic [TICK_W-1:0] sof_settle_ticks;
		logic [TICK_W-1:0] recover_ticks;
	} cfg_t;

	typedef struct packed {
		seq_state_t        seq;
		logic              speed;
		logic [TICK_W-1:0] delay;
	} ctx_t;

	typedef struct packed {
		logic [CODE_W-1:0] port_state;
		logic              low_speed;
		logic              remove_devices;
		logic              issue_bus_reset;
		logic              enable_sof;
		logic              add_device;
		logic              waiting;
	} result_t;

	function automatic logic [CODE_W-1:0] state_code(input seq_state_t s);
		logic [CODE_W-1:0] c;
		unique case (s)
			ST_WAITDEV: c = CODE_WAITDEV;
			ST_INIT:    c = CODE_INIT;
			ST_ILLEGAL: c = CODE_ILLEGAL;
			ST_SETTLE:  c = CODE_SETTLE;
			ST_RESET:   c = CODE_RESET;
			ST_WAITRST: c = CODE_WAITRST;
			ST_WAITSOF: c = CODE_WAITSOF;
			ST_RECOVER: c = CODE_RECOVER;
			ST_CONFIG:  c = CODE_CONFIG;
			ST_RUNNING: c = CODE_RUNNING;
			default:    c = CODE_WAITDEV;
		endcase
		return c;
	endfunction

endpackage : urpa_pkg

`default_nettype wire

### src/urpa_cfg_regs.sv
// ----------------------------------------------------------------------------
// urpa_cfg_regs
// Delay configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module urpa_cfg_regs import urpa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0] cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks     <= SETTLE_RESET;
			cfg_q.sof_settle_ticks <= SOF_SETTLE_RESET;
			cfg_q.recover_ticks    <= RECOVER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE:     cfg_q.settle_ticks     <= cfg_wdata;
				REG_SOF_SETTLE: cfg_q.sof_settle_ticks <= cfg_wdata;
				REG_RECOVER:    cfg_q.recover_ticks    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : urpa_cfg_regs

`default_nettype wire

### src/urpa_step.sv
// ----------------------------------------------------------------------------
// urpa_step
// Next-state and result logic for one poll or tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module urpa_step import urpa_pkg::*; (
	input  wire item_t item,
	input  wire ctx_t  ctx,
	input  wire cfg_t  cfg,
	output ctx_t    ctx_next,
	output result_t res
);

	always_comb begin
		seq_state_t        st;
		logic              spd;
		logic [TICK_W-1:0] dly;
		logic              done;
		logic              detached;
		logic              rm;
		logic              rst;
		logic              sof;
		logic              add;

		st       = ctx.seq;
		spd      = ctx.speed;
		dly      = ctx.delay;
		done     = 1'b0;
		rm       = 1'b0;
		rst      = 1'b0;
		sof      = 1'b0;
		add      = 1'b0;
		detached = (ctx.seq == ST_WAITDEV) || (ctx.seq == ST_INIT) || (ctx.seq == ST_ILLEGAL);

		if (item.opcode == OP_TICK) begin
			if (dly != '0) begin
				dly = dly - TICK_W'(1);
			end
		end else if (dly == '0) begin
			case (item.line_state) inside
				LINE_SE0: begin
					if (!detached) begin
						st = ST_INIT;
					end
				end
				LINE_SE1: st = ST_ILLEGAL;
				LINE_LOW, LINE_FULL: begin
					spd = (item.line_state == LINE_LOW);
					if (detached) begin
						st   = ST_SETTLE;
						done = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (!done) begin
				unique case (st)
					ST_INIT: begin
						rm = 1'b1;
						st = ST_WAITDEV;
					end
					ST_SETTLE: begin
						dly = cfg.settle_ticks;
						st  = ST_RESET;
					end
					ST_RESET: begin
						rst = 1'b1;
						st  = ST_WAITRST;
					end
					ST_WAITRST: begin
						if (!item.reset_busy) begin
							sof = 1'b1;
							st  = ST_WAITSOF;
						end
					end
					ST_WAITSOF: begin
						if (item.frame_seen) begin
							dly = cfg.sof_settle_ticks;
							st  = ST_RECOVER;
						end
					end
					ST_RECOVER: begin
						dly = cfg.recover_ticks;
						st  = ST_CONFIG;
					end
					ST_CONFIG: begin
						add = 1'b1;
						st  = ST_RUNNING;
					end
					default: begin
					end
				endcase
			end
		end

		ctx_next.seq   = st;
		ctx_next.speed = spd;
		ctx_next.delay = dly;

		res.port_state      = state_code(st);
		res.low_speed       = spd;
		res.remove_devices  = rm;
		res.issue_bus_reset = rst;
		res.enable_sof      = sof;
		res.add_device      = add;
		res.waiting         = (dly != '0);
	end

endmodule : urpa_step

`default_nettype wire

### src/usb_root_port_attach_sequencer.sv
// ----------------------------------------------------------------------------
// usb_root_port_attach_sequencer
// Walks a USB host root port from detach through bus reset to running.
// ----------------------------------------------------------------------------
// Every input item, a poll or a millisecond tick, gives exactly one result
// item. An item is latched into an input register, evaluated against the
// sequencer state and placed in the output register, where its result is
// offered; the evaluation waits while the output register is still full, and
// one item is taken every cycle as long as the output side keeps up. Delays
// are counted in ticks loaded from the configuration registers; polls that
// arrive while the delay counter is nonzero change nothing and carry no pulses.
`default_nettype none

module usb_root_port_attach_sequencer import urpa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// line_state[2:0], reset_busy[3], frame_seen[4], zero fill [7:5]
	input  wire logic [IDATA_W-1:0] s_tdata,
	// opcode[0]
	input  wire logic               s_tuser,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// port_state[3:0], low_speed[4], remove_devices[5], issue_bus_reset[6],
	// enable_sof[7], add_device[8], waiting[9], zero fill [15:10]
	output logic [ODATA_W-1:0]      m_tdata,
	input  wire logic               cfg_we,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [TICK_W-1:0]  cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	result_t res_s2;
	ctx_t    ctx_q;
	ctx_t    ctx_next;
	result_t res;
	logic    out_free;
	logic    step;

	urpa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	urpa_step u_step (
		.item     (item_s1),
		.ctx      (ctx_q),
		.cfg      (cfg),
		.ctx_next (ctx_next),
		.res      (res)
	);

	assign out_free = !valid_s2 || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode     <= s_tuser;
			item_s1.line_state <= s_tdata[2:0];
			item_s1.reset_busy <= s_tdata[3];
			item_s1.frame_seen <= s_tdata[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.seq   <= ST_WAITDEV;
			ctx_q.speed <= 1'b0;
			ctx_q.delay <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (step) begin
				ctx_q <= ctx_next;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.waiting, res_s2.add_device, res_s2.enable_sof,
		res_s2.issue_bus_reset, res_s2.remove_devices, res_s2.low_speed,
		res_s2.port_state};

endmodule : usb_root_port_attach_sequencer

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the USB root port attach sequencer.
// ----------------------------------------------------------------------------
// A short scripted walk through attach, bus reset, start-of-frame and recovery
// runs with the power-up register values. Random phases follow, each with its
// own delay settings. Zero delays, the largest delays and the power-up values
// are among them. Most random items follow the attach sequence, and the rest
// are noise. Every item's result is predicted in the bench. Results are
// compared field by field as they leave the block. Input bursts and output
// stalls are random, with long output hold-offs that back the block up.
module tb import urpa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [LINE_W-1:0] LINE_KEEP    = 3'd4;
	localparam logic [LINE_W-1:0] LINE_RSV_LO  = 3'd5;
	localparam logic [LINE_W-1:0] LINE_RSV_HI  = 3'd7;
	localparam logic [CIDX_W-1:0] REG_UNUSED   = 2'd3;
	localparam logic [TICK_W-1:0] TICKS_MAX    = 16'hFFFF;
	localparam result_t           NO_WANT      = '0;

	typedef struct {
		logic              op;
		logic [LINE_W-1:0] line;
		logic              busy;
		logic              frame;
		int                reps;
		bit                typed;
		result_t           want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IDATA_W-1:0] s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [ODATA_W-1:0] m_tdata;
	logic               cfg_we = 1'b0;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [TICK_W-1:0]  cfg_wdata = '0;

	usb_root_port_attach_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	logic [CODE_W-1:0] port_code      = CODE_WAITDEV;
	logic              port_low_speed = 1'b0;
	logic [TICK_W-1:0] delay_left     = '0;
	logic [TICK_W-1:0] settle_len     = SETTLE_RESET;
	logic [TICK_W-1:0] sof_settle_len = SOF_SETTLE_RESET;
	logic [TICK_W-1:0] recover_len    = RECOVER_RESET;

	result_t awaited_results [$];
	int      fail_count = 0;
	int      burst_left = 1;

	int      taken_count = 0;
	int      next_hold = 300;
	int      hold_left = 0;
	int      rx_mode = 0;
	int      mode_left = 0;

	script_row_t opening_rows [25] = '{
		'{OP_TICK, LINE_SE1,    1'b1, 1'b1, 1,   1'b1,
			'{CODE_WAITDEV, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_KEEP,   1'b0, 1'b0, 1,   1'b1,
			'{CODE_WAITDEV, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_SE0,    1'b1, 1'b1, 1,   1'b1,
			'{CODE_WAITDEV, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_SE1,    1'b0, 1'b0, 1,   1'b1,
			'{CODE_ILLEGAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_RSV_HI, 1'b1, 1'b1, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_FULL,   1'b0, 1'b0, 1,   1'b1,
			'{CODE_SETTLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_LOW,    1'b0, 1'b0, 1,   1'b1,
			'{CODE_RESET, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{OP_POLL, LINE_RSV_LO, 1'b0, 1'b1, 1,   1'b0, NO_WANT},
		'{OP_TICK, LINE_SE0,    1'b0, 1'b0, 199, 1'b0, NO_WANT},
		'{OP_TICK, LINE_KEEP,   1'b1, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_TICK, LINE_KEEP,   1'b0, 1'b1, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b1, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b1, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_RSV_LO, 1'b0, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b0, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b0, 1'b1, 1,   1'b0, NO_WANT},
		'{OP_TICK, LINE_KEEP,   1'b0, 1'b0, 200, 1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b0, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_TICK, LINE_KEEP,   1'b0, 1'b0, 20,  1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b0, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_KEEP,   1'b1, 1'b1, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_SE0,    1'b0, 1'b0, 1,   1'b1,
			'{CODE_WAITDEV, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_LOW,    1'b0, 1'b0, 1,   1'b0, NO_WANT},
		'{OP_POLL, LINE_SE1,    1'b0, 1'b0, 1,   1'b1,
			'{CODE_ILLEGAL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_POLL, LINE_FULL,   1'b0, 1'b0, 1,   1'b0, NO_WANT}
	};

	function automatic result_t advance_port(logic op, logic [LINE_W-1:0] line,
			logic busy, logic frame);
		result_t res;
		bit      detached;
		bit      just_attached;
		res = '0;
		just_attached = 1'b0;
		detached = (port_code == CODE_WAITDEV) || (port_code == CODE_INIT) ||
			(port_code == CODE_ILLEGAL);
		if (op == OP_TICK) begin
			if (delay_left != 0) delay_left = delay_left - 1'b1;
		end else if (delay_left == 0) begin
			if (line == LINE_SE0) begin
				if (!detached) port_code = CODE_INIT;
			end else if (line == LINE_SE1) begin
				port_code = CODE_ILLEGAL;
			end else if (line == LINE_LOW || line == LINE_FULL) begin
				port_low_speed = (line == LINE_LOW);
				if (detached) begin
					port_code = CODE_SETTLE;
					just_attached = 1'b1;
				end
			end
			if (!just_attached) begin
				case (port_code)
					CODE_INIT: begin
						res.remove_devices = 1'b1;
						port_code = CODE_WAITDEV;
					end
					CODE_SETTLE: begin
						delay_left = settle_len;
						port_code = CODE_RESET;
					end
					CODE_RESET: begin
						res.issue_bus_reset = 1'b1;
						port_code = CODE_WAITRST;
					end
					CODE_WAITRST: begin
						if (!busy) begin
							res.enable_sof = 1'b1;
							port_code = CODE_WAITSOF;
						end
					end
					CODE_WAITSOF: begin
						if (frame) begin
							delay_left = sof_settle_len;
							port_code = CODE_RECOVER;
						end
					end
					CODE_RECOVER: begin
						delay_left = recover_len;
						port_code = CODE_CONFIG;
					end
					CODE_CONFIG: begin
						res.add_device = 1'b1;
						port_code = CODE_RUNNING;
					end
					default: ;
				endcase
			end
		end
		res.port_state = port_code;
		res.low_speed = port_low_speed;
		res.waiting = (delay_left != 0);
		return res;
	endfunction

	task automatic push_item(logic op, logic [LINE_W-1:0] line, logic busy, logic frame,
			bit typed, result_t want);
		result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, frame, busy, line};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = advance_port(op, line, busy, frame);
		awaited_results.push_back(typed ? want : predicted);
		if (burst_left != 0) burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 40);
		end
	endtask

	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_SETTLE:     settle_len = value;
			REG_SOF_SETTLE: sof_settle_len = value;
			REG_RECOVER:    recover_len = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_setup(logic [TICK_W-1:0] settle, logic [TICK_W-1:0] sof_settle,
			logic [TICK_W-1:0] recover);
		settle_pipeline();
		write_reg(REG_UNUSED, TICK_W'($urandom_range(0, 16'hFFFF)));
		write_reg(REG_SETTLE, settle);
		write_reg(REG_SOF_SETTLE, sof_settle);
		write_reg(REG_RECOVER, recover);
		cfg_we <= 1'b0;
	endtask

	// In tidy mode the walk runs until one device has been announced.
	task automatic run_random(int count, bit tidy);
		logic              op;
		logic [LINE_W-1:0] line;
		logic              busy;
		logic              frame;
		int                sent;
		bit                announced;
		sent = 0;
		announced = 1'b0;
		while (tidy ? !announced : (sent < count)) begin
			op = OP_POLL;
			line = LINE_W'($urandom_range(LINE_KEEP, LINE_RSV_HI));
			busy = 1'($urandom_range(0, 1));
			frame = 1'($urandom_range(0, 1));
			if (!tidy && $urandom_range(0, 99) < 20) begin
				op = 1'($urandom_range(0, 1));
				line = LINE_W'($urandom_range(0, LINE_RSV_HI));
			end else if (delay_left != 0) begin
				if ($urandom_range(0, 99) < (tidy ? 97 : 85)) op = OP_TICK;
				else line = LINE_W'($urandom_range(0, LINE_RSV_HI));
			end else begin
				case (port_code) inside
					CODE_WAITDEV, CODE_INIT, CODE_ILLEGAL:
						line = LINE_W'($urandom_range(LINE_LOW, LINE_FULL));
					CODE_WAITRST:
						busy = ($urandom_range(0, 99) < 40);
					CODE_SETTLE, CODE_RESET, CODE_RECOVER, CODE_CONFIG:
						if ($urandom_range(0, 9) == 0)
							line = LINE_W'($urandom_range(LINE_LOW, LINE_FULL));
					CODE_RUNNING: begin
						if (tidy || $urandom_range(0, 99) < 30)
							line = (!tidy && $urandom_range(0, 9) == 0) ? LINE_SE1 : LINE_SE0;
						else if ($urandom_range(0, 1) != 0)
							op = OP_TICK;
					end
					default: ;
				endcase
			end
			push_item(op, line, busy, frame, 1'b0, NO_WANT);
			if (port_code == CODE_RUNNING && delay_left == 0 &&
				awaited_results[$].add_device) announced = 1'b1;
			sent++;
		end
	endtask

	task automatic flag_field(string name, logic [CODE_W-1:0] want, logic [CODE_W-1:0] got);
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (m_tvalid && m_tready) begin
			got.port_state = m_tdata[3:0];
			got.low_speed = m_tdata[4];
			got.remove_devices = m_tdata[5];
			got.issue_bus_reset = m_tdata[6];
			got.enable_sof = m_tdata[7];
			got.add_device = m_tdata[8];
			got.waiting = m_tdata[9];
			if (awaited_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (got.port_state !== want.port_state)
					flag_field("port_state", want.port_state, got.port_state);
				if (got.low_speed !== want.low_speed)
					flag_field("low_speed", CODE_W'(want.low_speed), CODE_W'(got.low_speed));
				if (got.remove_devices !== want.remove_devices)
					flag_field("remove_devices", CODE_W'(want.remove_devices),
						CODE_W'(got.remove_devices));
				if (got.issue_bus_reset !== want.issue_bus_reset)
					flag_field("issue_bus_reset", CODE_W'(want.issue_bus_reset),
						CODE_W'(got.issue_bus_reset));
				if (got.enable_sof !== want.enable_sof)
					flag_field("enable_sof", CODE_W'(want.enable_sof), CODE_W'(got.enable_sof));
				if (got.add_device !== want.add_device)
					flag_field("add_device", CODE_W'(want.add_device), CODE_W'(got.add_device));
				if (got.waiting !== want.waiting)
					flag_field("waiting", CODE_W'(want.waiting), CODE_W'(got.waiting));
			end
		end
	end

	// Every few hundred items the output side holds off long enough to back up the block.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) taken_count++;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (taken_count >= next_hold) begin
			hold_left = 80;
			next_hold += 600;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	initial begin
		#30_000_000;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		int i;
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < $size(opening_rows); i++) begin
			for (k = 0; k < opening_rows[i].reps; k++) begin
				push_item(opening_rows[i].op, opening_rows[i].line, opening_rows[i].busy,
					opening_rows[i].frame, opening_rows[i].typed, opening_rows[i].want);
			end
		end
		load_setup('0, '0, '0);
		run_random(250, 1'b0);
		load_setup(TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)),
			TICK_W'($urandom_range(1, 6)));
		run_random(0, 1'b1);
		run_random(300, 1'b0);
		load_setup(TICKS_MAX, TICKS_MAX, TICKS_MAX);
		run_random(100, 1'b0);
		load_setup(TICK_W'($urandom_range(0, 3)), 16'd1, TICK_W'($urandom_range(0, 5)));
		run_random(300, 1'b0);
		load_setup(SETTLE_RESET, SOF_SETTLE_RESET, RECOVER_RESET);
		run_random(200, 1'b0);
		load_setup(TICK_W'($urandom_range(0, 2)), TICK_W'($urandom_range(0, 2)),
			TICK_W'($urandom_range(0, 2)));
		run_random(250, 1'b0);
		settle_pipeline();
		if (fail_count == 0 && awaited_results.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule : tb

### filelist.f
src/urpa_pkg.sv
src/urpa_cfg_regs.sv
src/urpa_step.sv
src/usb_root_port_attach_sequencer.sv
tb/tb.sv
